[rtl/core/brls_pkg.sv]
// ---------------------------------------------------------------------------
// brls_pkg
// Shared types for the bit run-length statistics core: the input and output
// words and the control group that drives the run tracking unit.
// ---------------------------------------------------------------------------
package brls_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_sample;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  stat_index;
    logic [15:0] stat_value;
    logic        last_stat;
  } out_word_t;

  typedef struct packed {
    logic step;
    logic bit_in;
    logic close_final;
    logic clear;
  } run_ctl_t;

endpackage

[rtl/core/brls_run_unit.sv]
// ---------------------------------------------------------------------------
// brls_run_unit
// Run tracker and statistics store. Takes one sample bit per step, closes
// finished runs into the per-value length histogram, and keeps the longest
// run and the run total. All counters saturate.
// ---------------------------------------------------------------------------
module brls_run_unit #(
  parameter int RUN_BUCKETS = 6,
  parameter int COUNT_WIDTH = 16,
  parameter int IDX_W       = $clog2(2 * RUN_BUCKETS + 2)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  brls_pkg::run_ctl_t     ctl,
  input  logic [IDX_W-1:0]       rd_idx,
  output logic [COUNT_WIDTH-1:0] rd_value
);
  import brls_pkg::*;

  localparam int NH   = 2 * RUN_BUCKETS;
  localparam int HW   = $clog2(NH);
  localparam int SW   = (RUN_BUCKETS > 2) ? $clog2(RUN_BUCKETS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0] run_r;
  logic                   prev_r;
  logic                   have_r;
  logic [COUNT_WIDTH-1:0] hist_r [NH];
  logic [COUNT_WIDTH-1:0] longest_r;
  logic [COUNT_WIDTH-1:0] total_r;

  logic                   same;
  logic                   closing;
  logic [COUNT_WIDTH-1:0] run_inc;
  logic [SW-1:0]          slot;
  logic [HW-1:0]          hidx;
  logic [COUNT_WIDTH-1:0] last_len;

  assign same     = (ctl.bit_in == prev_r);
  assign closing  = have_r && ((ctl.step && !same) || ctl.close_final);
  assign run_inc  = (run_r == CNT_MAX) ? run_r : run_r + 1'b1;
  assign last_len = run_r - 1'b1;
  assign slot     = (run_r >= COUNT_WIDTH'(RUN_BUCKETS)) ? SW'(RUN_BUCKETS - 1)
                                                         : last_len[SW-1:0];
  assign hidx     = prev_r ? HW'(RUN_BUCKETS) + HW'(slot) : HW'(slot);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      run_r     <= '0;
      prev_r    <= 1'b0;
      have_r    <= 1'b0;
      longest_r <= '0;
      total_r   <= '0;
      for (int i = 0; i < NH; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (ctl.step) begin
        if (!have_r || !same) begin
          run_r  <= COUNT_WIDTH'(1);
          prev_r <= ctl.bit_in;
          have_r <= 1'b1;
        end else begin
          run_r <= run_inc;
        end
      end
      if (closing) begin
        for (int i = 0; i < NH; i++) begin
          if (hidx == HW'(i) && hist_r[i] != CNT_MAX) begin
            hist_r[i] <= hist_r[i] + 1'b1;
          end
        end
        if (run_r > longest_r) begin
          longest_r <= run_r;
        end
        if (total_r != CNT_MAX) begin
          total_r <= total_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (rd_idx < IDX_W'(NH)) begin
      rd_value = hist_r[rd_idx[HW-1:0]];
    end else if (rd_idx == IDX_W'(NH)) begin
      rd_value = longest_r;
    end else begin
      rd_value = total_r;
    end
  end

endmodule

[rtl/core/bit_run_length_statistics_core.sv]
// ---------------------------------------------------------------------------
// bit_run_length_statistics_core
// Runs test statistics over a bit stream, one bit per clock during a scan.
//
// Input channel in_valid/in_stall/in_word carries 32-bit sample words, bit 0
// first; the low WORD_BITS bits are used. end_of_sample marks the last word.
// Each accepted word occupies the bit-serial run unit, one bit per cycle;
// in_stall is high meanwhile, so the next word is taken only once the
// scan of the current word is done.
// On the last word a close state ends the final run, then 2*RUN_BUCKETS+2
// words (14 by default) leave on out_valid/out_stall/out_word: zero-run
// buckets, one-run buckets, longest run, run total, last_stat on the final
// one. The first statistic is registered after the last word's scan, the
// close state and the first emit step. The emit sequencer holds while
// out_stall is high, and the output register lets the next input word
// be accepted while the final statistic still waits. All statistics
// clear when the final statistic is loaded. Reset clears the control
// state and statistics, not data_r or out_word_r; no clearing pass.
// ---------------------------------------------------------------------------
module bit_run_length_statistics_core #(
  parameter int WORD_BITS   = 32,
  parameter int RUN_BUCKETS = 6,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  brls_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output brls_pkg::out_word_t out_word
);
  import brls_pkg::*;

  localparam int BW    = $clog2(WORD_BITS);
  localparam int NSTAT = 2 * RUN_BUCKETS + 2;
  localparam int IDX_W = $clog2(NSTAT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_CLOSE = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [WORD_BITS-1:0]   data_r, data_nxt;
  logic [BW-1:0]          bit_cnt_r, bit_cnt_nxt;
  logic                   end_r, end_nxt;
  logic [IDX_W-1:0]       emit_r, emit_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  run_ctl_t               ctl;
  logic [COUNT_WIDTH-1:0] rd_value;
  logic                   out_load;
  logic                   emit_last;
  logic [63:0]            data_wide;
  logic [31:0]            value_wide;
  logic [31:0]            index_wide;

  assign data_wide  = 64'(in_word.data_word);
  assign value_wide = 32'(rd_value);
  assign index_wide = 32'(emit_r);
  assign emit_last  = (emit_r == IDX_W'(NSTAT - 1));
  assign out_load   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  assign ctl.step        = (state_r == S_SCAN);
  assign ctl.bit_in      = data_r[0];
  assign ctl.close_final = (state_r == S_CLOSE);
  assign ctl.clear       = out_load && emit_last;

  brls_run_unit #(
    .RUN_BUCKETS(RUN_BUCKETS),
    .COUNT_WIDTH(COUNT_WIDTH),
    .IDX_W      (IDX_W)
  ) u_run (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_idx  (emit_r),
    .rd_value(rd_value)
  );

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    bit_cnt_nxt   = bit_cnt_r;
    end_nxt       = end_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          data_nxt    = data_wide[WORD_BITS-1:0];
          end_nxt     = in_word.end_of_sample;
          bit_cnt_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        data_nxt    = data_r >> 1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BW'(WORD_BITS - 1)) begin
          state_nxt = end_r ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        emit_nxt  = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.stat_index = index_wide[3:0];
          out_word_nxt.stat_value = value_wide[15:0];
          out_word_nxt.last_stat  = emit_last;
          emit_nxt                = emit_r + 1'b1;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      emit_r      <= '0;
      end_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      emit_r      <= emit_nxt;
      end_r       <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
